// ===== rtl/nucleotide_packer_gc_binner_macros.svh =====
// Assertion helpers shared by the packer modules.
`ifndef NUCLEOTIDE_PACKER_GC_BINNER_MACROS_SVH
`define NUCLEOTIDE_PACKER_GC_BINNER_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define NPK_ASSERT(label, clk_s, rst_s, expr) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) \
        else $error("npk: assertion failed");

// When the first expression holds, the second must hold in the next cycle.
`define NPK_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("npk: assertion failed");

`else

`define NPK_ASSERT(label, clk_s, rst_s, expr)
`define NPK_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== rtl/npk_pkg.sv =====
package npk_pkg;

    typedef enum logic [1:0] {
        PHASE_SEEK,
        PHASE_PACK,
        PHASE_DONE
    } phase_t;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEQUENCE_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GC_ENABLE       = 1'd1;

    localparam logic [1:0] KIND_WORD = 2'd0;
    localparam logic [1:0] KIND_BIN  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam int CODE_W         = 3;
    localparam int SHIFT_W        = 15;
    localparam int SLOT_W         = 3;
    localparam int WORD_W         = 16;
    localparam int COUNT_W        = 32;
    localparam int START_W        = 33;
    localparam int CODES_PER_WORD = 5;

    localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
    localparam logic [CODE_W-1:0] CODE_A    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_C    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_G    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_T    = 3'd4;

    localparam logic [WORD_W-1:0] BAD_BIN = 16'd255;

    localparam logic [7:0] GRAPHIC_FIRST = 8'h21;
    localparam logic [7:0] GRAPHIC_LAST  = 8'h7E;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         item_kind;
        logic [WORD_W-1:0]  item_value;
        logic [START_W-1:0] start_position;
        logic               load_error;
        logic               last_of_run;
    } out_item_t;

    // Results of one step. The word slot holds either a completed word, which
    // goes out before the bin, or a flushed partial word, which goes out after it.
    typedef struct packed {
        logic               word_valid;
        logic               word_after_bin;
        logic [WORD_W-1:0]  word;
        logic               bin_valid;
        logic [WORD_W-1:0]  bin_value;
        logic               done_valid;
        logic [START_W-1:0] start;
        logic               error;
    } bundle_t;

    function automatic logic is_graphic(input logic [7:0] ch);
        return (ch >= GRAPHIC_FIRST) && (ch <= GRAPHIC_LAST);
    endfunction

    function automatic logic [CODE_W-1:0] base_code(input logic [7:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            "A", "a": code = CODE_A;
            "C", "c": code = CODE_C;
            "G", "g": code = CODE_G;
            "T", "t": code = CODE_T;
            default:  code = CODE_NONE;
        endcase
        return code;
    endfunction

    // Left-aligns a partial word that holds the given number of codes.
    function automatic logic [WORD_W-1:0] flush_word(input logic [SHIFT_W-1:0] shift,
                                                     input logic [SLOT_W-1:0]  slot);
        logic [WORD_W-1:0] w;
        case (slot)
            3'd1:    w = {1'b0, shift[2:0], 12'b0};
            3'd2:    w = {1'b0, shift[5:0], 9'b0};
            3'd3:    w = {1'b0, shift[8:0], 6'b0};
            3'd4:    w = {1'b0, shift[11:0], 3'b0};
            default: w = {1'b0, shift};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/npk_stream_if.sv =====
interface npk_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/nucleotide_packer_gc_binner.sv =====
// Packs FASTA text into 16-bit words of five 3-bit base codes, optionally
// reports G+C counts per bin of BIN_SIZE bases, and ends with one done item
// carrying the start position and an error flag. A character waits in the
// input register until its results load into the result register. The single
// result port limits the rate: a character with more than one result (at most
// three) holds the input until all but the last have left, so a stream with at
// most one result per character runs at one character per cycle while the
// output is ready. Configuration is taken on any cycle with cfg_write_en high;
// after done, characters are consumed without results until reset.
module nucleotide_packer_gc_binner
    import npk_pkg::*;
#(
    parameter int BIN_SIZE = 100
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    npk_stream_if.sink             char_stream,
    npk_stream_if.source           item_stream
);

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      in_ready;
    logic      can_load;
    logic      step_en;
    bundle_t   results;
    out_item_t out_item;
    logic      out_valid;

    assign step_en           = in_valid_reg && can_load;
    assign in_ready          = !in_valid_reg || step_en;
    assign char_stream.ready = in_ready;
    assign in_valid_next     = in_ready ? char_stream.valid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && char_stream.valid)
        begin
            in_item_reg <= char_stream.payload;
        end
    end

    npk_step_core #(
        .BIN_SIZE (BIN_SIZE)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step_en      (step_en),
        .item         (in_item_reg),
        .results      (results)
    );

    npk_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (step_en),
        .load      (results),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (item_stream.ready),
        .out_item  (out_item)
    );

    assign item_stream.valid   = out_valid;
    assign item_stream.payload = out_item;

endmodule

// ===== rtl/npk_step_core.sv =====
`include "nucleotide_packer_gc_binner_macros.svh"

module npk_step_core
    import npk_pkg::*;
#(
    parameter int BIN_SIZE = 100
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   step_en,
    input  in_item_t               item,
    output bundle_t                results
);

    // Bin counters must hold one past the bin size: with a bin of one base the
    // first bin spans two.
    localparam int BIN_W = $clog2(BIN_SIZE + 2);
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_SIZE);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CODES_PER_WORD - 1);

    logic [COUNT_W-1:0] seq_len_reg;
    logic               gc_en_reg;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] skipped_reg, skipped_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [BIN_W-1:0]   bin_pos_reg, bin_pos_next;
    logic [BIN_W-1:0]   at_reg, at_next;
    logic [BIN_W-1:0]   gc_reg, gc_next;

    logic               graphic;
    logic [CODE_W-1:0]  code;
    logic               code_is_gc;
    logic               code_is_at;
    logic [COUNT_W:0]   total_inc;
    logic               full_now;
    logic               full_after;
    logic               exact_now;
    logic               exact_after;
    logic [SHIFT_W-1:0] shifted;
    logic [BIN_W-1:0]   bin_step;
    logic [BIN_W:0]     bin_sum;
    logic               finish;
    logic               finish_err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= COUNT_W'(1);
            gc_en_reg   <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_SEQUENCE_LENGTH: seq_len_reg <= cfg_data;
                CFG_GC_ENABLE:       gc_en_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    assign graphic     = is_graphic(item.char_byte);
    assign code        = base_code(item.char_byte);
    assign code_is_gc  = (code == CODE_C) || (code == CODE_G);
    assign code_is_at  = (code == CODE_A) || (code == CODE_T);
    assign total_inc   = {1'b0, total_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign full_now    = total_reg >= seq_len_reg;
    assign exact_now   = total_reg == seq_len_reg;
    assign full_after  = total_inc >= {1'b0, seq_len_reg};
    assign exact_after = total_inc == {1'b0, seq_len_reg};
    assign shifted     = {shift_reg[SHIFT_W-CODE_W-1:0], code};
    assign bin_step    = bin_pos_reg + BIN_W'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        skipped_next = skipped_reg;
        total_next   = total_reg;
        shift_next   = shift_reg;
        slot_next    = slot_reg;
        bin_pos_next = bin_pos_reg;
        at_next      = at_reg;
        gc_next      = gc_reg;
        results      = '0;
        finish       = 1'b0;
        finish_err   = 1'b0;
        bin_sum      = '0;

        case (phase_reg)
            PHASE_SEEK:
            begin
                if (full_now || item.end_of_input)
                begin
                    finish     = 1'b1;
                    finish_err = 1'b1;
                end
                else if (graphic)
                begin
                    total_next = total_inc[COUNT_W-1:0];
                    if (code == CODE_NONE)
                    begin
                        skipped_next = skipped_reg + COUNT_W'(1);
                        finish       = full_after;
                        finish_err   = 1'b1;
                    end
                    else
                    begin
                        // The first base is counted in the first bin whatever
                        // the GC setting.
                        phase_next   = PHASE_PACK;
                        shift_next   = SHIFT_W'(code);
                        slot_next    = SLOT_W'(1);
                        bin_pos_next = BIN_W'(1);
                        at_next      = BIN_W'(code_is_at);
                        gc_next      = BIN_W'(code_is_gc);
                        finish       = full_after;
                        finish_err   = !exact_after;
                    end
                end
            end
            PHASE_PACK:
            begin
                if (full_now || item.end_of_input)
                begin
                    finish     = 1'b1;
                    finish_err = !exact_now;
                end
                else if (graphic)
                begin
                    total_next = total_inc[COUNT_W-1:0];
                    if (slot_reg == SLOT_LAST)
                    begin
                        results.word_valid = 1'b1;
                        results.word       = WORD_W'(shifted);
                        shift_next         = '0;
                        slot_next          = '0;
                    end
                    else
                    begin
                        shift_next = shifted;
                        slot_next  = slot_reg + SLOT_W'(1);
                    end
                    if (gc_en_reg)
                    begin
                        at_next = at_reg + BIN_W'(code_is_at);
                        gc_next = gc_reg + BIN_W'(code_is_gc);
                        bin_sum = {1'b0, at_next} + {1'b0, gc_next};
                        if (bin_step >= BIN_LAST)
                        begin
                            results.bin_valid = 1'b1;
                            results.bin_value = (bin_sum == {1'b0, BIN_LAST})
                                                ? WORD_W'(gc_next) : BAD_BIN;
                            bin_pos_next      = '0;
                            at_next           = '0;
                            gc_next           = '0;
                        end
                        else
                        begin
                            bin_pos_next = bin_step;
                        end
                    end
                    finish     = full_after;
                    finish_err = !exact_after;
                end
            end
            default:
            begin
            end
        endcase

        if (finish)
        begin
            if ((phase_next == PHASE_PACK) && (shift_next != '0) && (slot_next != '0))
            begin
                results.word_valid     = 1'b1;
                results.word_after_bin = 1'b1;
                results.word           = flush_word(shift_next, slot_next);
            end
            phase_next         = PHASE_DONE;
            results.done_valid = 1'b1;
            results.start      = {1'b0, skipped_next} + {{COUNT_W{1'b0}}, 1'b1};
            results.error      = finish_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PHASE_SEEK;
            skipped_reg <= '0;
            total_reg   <= '0;
            shift_reg   <= '0;
            slot_reg    <= '0;
            bin_pos_reg <= '0;
            at_reg      <= '0;
            gc_reg      <= '0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            skipped_reg <= skipped_next;
            total_reg   <= total_next;
            shift_reg   <= shift_next;
            slot_reg    <= slot_next;
            bin_pos_reg <= bin_pos_next;
            at_reg      <= at_next;
            gc_reg      <= gc_next;
        end
    end

    `NPK_ASSERT_NEXT(a_done_holds, clk, rst_n, phase_reg == PHASE_DONE, phase_reg == PHASE_DONE)
    `NPK_ASSERT(a_slot_below_word, clk, rst_n, slot_reg <= SLOT_LAST)
    `NPK_ASSERT(a_pack_has_base, clk, rst_n, phase_reg != PHASE_PACK || total_reg != skipped_reg)

endmodule

// ===== rtl/npk_result_queue.sv =====
`include "nucleotide_packer_gc_binner_macros.svh"

module npk_result_queue
    import npk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_en,
    input  bundle_t   load,
    output logic      can_load,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    bundle_t    bundle_reg, bundle_next;
    logic [1:0] pending;
    logic       pop;
    logic       sel_word_early;
    logic       sel_bin;
    logic       sel_word_late;

    assign pending   = 2'(bundle_reg.word_valid) + 2'(bundle_reg.bin_valid)
                     + 2'(bundle_reg.done_valid);
    assign out_valid = pending != 2'd0;
    assign pop       = out_valid && out_ready;
    // A new step may load as soon as the last pending result leaves.
    assign can_load  = (pending == 2'd0) || ((pending == 2'd1) && out_ready);

    assign sel_word_early = bundle_reg.word_valid && !bundle_reg.word_after_bin;
    assign sel_bin        = !sel_word_early && bundle_reg.bin_valid;
    assign sel_word_late  = !sel_word_early && !bundle_reg.bin_valid && bundle_reg.word_valid;

    always_comb
    begin
        out_item             = '0;
        out_item.last_of_run = pending == 2'd1;
        if (sel_word_early || sel_word_late)
        begin
            out_item.item_kind  = KIND_WORD;
            out_item.item_value = bundle_reg.word;
        end
        else if (sel_bin)
        begin
            out_item.item_kind  = KIND_BIN;
            out_item.item_value = bundle_reg.bin_value;
        end
        else
        begin
            out_item.item_kind      = KIND_DONE;
            out_item.start_position = bundle_reg.start;
            out_item.load_error     = bundle_reg.error;
        end
    end

    always_comb
    begin
        bundle_next = bundle_reg;
        if (pop)
        begin
            if (sel_word_early || sel_word_late)
            begin
                bundle_next.word_valid = 1'b0;
            end
            else if (sel_bin)
            begin
                bundle_next.bin_valid = 1'b0;
            end
            else
            begin
                bundle_next.done_valid = 1'b0;
            end
        end
        if (load_en)
        begin
            bundle_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bundle_reg <= '0;
        end
        else
        begin
            bundle_reg <= bundle_next;
        end
    end

    `NPK_ASSERT(a_done_is_last, clk, rst_n, !(out_valid && out_item.item_kind == KIND_DONE) || out_item.last_of_run)

endmodule
